/* hw/rtl/sbfc_pkg.sv */
// ----------------------------------------------------------------------------
// sbfc_pkg: shared types and constants of the size-binned free block cache
// Command and status codes, register indexes, controller states.
// ----------------------------------------------------------------------------
package sbfc_pkg;

    localparam int BINS_DEF          = 19;
    localparam int SLOTS_PER_BIN_DEF = 16;
    localparam int HANDLE_BITS_DEF   = 16;
    localparam int SIZE_BITS_DEF     = 40;

    localparam int REQ_W    = 40;
    localparam int BYTES_W  = 45;
    localparam int FREED_W  = 49;
    localparam int STAMP_W  = 32;
    localparam int LOG_W    = 6;
    localparam int EXC_W    = 8;
    localparam int CFG_W    = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [5:0] FIRST_RST  = 6'd12;
    localparam logic [5:0] LAST_RST   = 6'd30;
    localparam logic [7:0] EXCESS_RST = 8'd32;

    typedef enum logic [1:0] {
        CMD_RETURN = 2'd0,
        CMD_ALLOC  = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CACHED  = 3'd0,
        ST_PASS    = 3'd1,
        ST_HIT     = 3'd2,
        ST_MISS    = 3'd3,
        ST_CLEARED = 3'd4
    } status_t;

    localparam logic [1:0] REG_FIRST  = 2'd0;
    localparam logic [1:0] REG_LAST   = 2'd1;
    localparam logic [1:0] REG_EXCESS = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_CLRSWEEP,
        S_RET_SCAN,
        S_RET_WAIT,
        S_RET_DONE,
        S_AL_BIN,
        S_AL_SCAN,
        S_AL_WAIT,
        S_AL_EVAL,
        S_AL_TAKE,
        S_CL_SUM,
        S_DONE
    } state_t;

endpackage

/* hw/rtl/size_binned_free_block_cache_top.sv */
// ----------------------------------------------------------------------------
// size_binned_free_block_cache_top: power-of-two binned free block cache
// Slots live in one synchronous RAM; a sequencer scans bins per command.
// ----------------------------------------------------------------------------
// Usage: raise start with command, request_size, block_handle while busy is
// low; the item is taken at that edge and busy rises. Exactly one result per
// item appears on status/granted_handle/granted_size/freed_bytes for one
// cycle, marked by done; busy falls at the edge that ends that cycle. The
// receiver cannot stall. The next item can be taken once busy is low again.
// Return: the first free slot of the size's bin is written; a full bin or an
// out-of-range size passes. Allocate: from the size's bin upward, one slot per
// cycle is read from the slot RAM and the smallest fitting block is taken.
// Clear: sums all bin byte tallies, then empties every bin. Valid bits are
// one mask word per bin in a small register array, cleared at reset and by
// clear. Configuration (cfg_we/cfg_index/cfg_data) must be written only while
// busy is low, not enforced here; writes to unknown indexes are dropped.
// Reset (rst_n low, asynchronous) restores register defaults, empties every
// bin and zeroes the insert counter.
// ----------------------------------------------------------------------------
module size_binned_free_block_cache_top #(
    parameter int BINS          = sbfc_pkg::BINS_DEF,
    parameter int SLOTS_PER_BIN = sbfc_pkg::SLOTS_PER_BIN_DEF,
    parameter int HANDLE_BITS   = sbfc_pkg::HANDLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    command,
    input  logic [sbfc_pkg::REQ_W-1:0]    request_size,
    input  logic [HANDLE_BITS-1:0]        block_handle,
    output logic                          done,
    output logic [2:0]                    status,
    output logic [HANDLE_BITS-1:0]        granted_handle,
    output logic [sbfc_pkg::REQ_W-1:0]    granted_size,
    output logic [sbfc_pkg::FREED_W-1:0]  freed_bytes,
    input  logic                          cfg_we,
    input  logic [sbfc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sbfc_pkg::CFG_W-1:0]    cfg_data
);
    localparam int NSLOTS = BINS * SLOTS_PER_BIN;
    localparam int AW  = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;
    localparam int KW  = (SLOTS_PER_BIN > 1) ? $clog2(SLOTS_PER_BIN) : 1;
    localparam int KCW = $clog2(SLOTS_PER_BIN + 1);
    localparam int BW  = $clog2(BINS + 1);
    localparam int BIW = (BINS > 1) ? $clog2(BINS) : 1;
    localparam int SW  = sbfc_pkg::SIZE_BITS_DEF;
    localparam int WW  = SW + HANDLE_BITS + sbfc_pkg::STAMP_W;
    localparam int RW  = sbfc_pkg::REQ_W;
    localparam int PW  = RW + sbfc_pkg::EXC_W;
    localparam int BYW = sbfc_pkg::BYTES_W;

    // ---------------- config ----------------
    logic [5:0] first_reg, last_reg;
    logic [7:0] excess_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg  <= sbfc_pkg::FIRST_RST;
            last_reg   <= sbfc_pkg::LAST_RST;
            excess_reg <= sbfc_pkg::EXCESS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sbfc_pkg::REG_FIRST:  first_reg  <= cfg_data[5:0];
                sbfc_pkg::REG_LAST:   last_reg   <= cfg_data[5:0];
                sbfc_pkg::REG_EXCESS: excess_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- slot memory ----------------
    logic [WW-1:0] slot_mem [NSLOTS];
    logic [WW-1:0] rd_data;
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [WW-1:0] mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            slot_mem[mem_waddr] <= mem_wdata;
        rd_data <= slot_mem[mem_raddr];
    end

    logic [SLOTS_PER_BIN-1:0] vmask_reg [BINS];
    logic [SLOTS_PER_BIN-1:0] cur_mask, mask_wdata;
    logic [BYW-1:0] bytes_mem [BINS];

    // ---------------- control ----------------
    sbfc_pkg::state_t state_reg, state_next;
    logic [1:0]       cmd_reg, cmd_next;
    logic [RW-1:0]    size_reg, size_next;
    logic [HANDLE_BITS-1:0] hnd_reg, hnd_next;
    logic [SW:0]      upper_reg, upper_next;     // one extra bit: saturated flag free
    logic [BW-1:0]    nb_reg, nb_next;
    logic [BW-1:0]    bin_reg, bin_next;
    logic [KCW-1:0]   k_reg, k_next;
    logic [KW-1:0]    rk_reg, rk_next;           // slot index of data in rd_data
    logic             rdv_reg, rdv_next;
    logic             found_reg, found_next;
    logic [KW-1:0]    best_k_reg, best_k_next;
    logic [SW-1:0]    best_size_reg, best_size_next;
    logic [HANDLE_BITS-1:0] best_hnd_reg, best_hnd_next;
    logic [31:0]      best_age_reg, best_age_next;
    logic [31:0]      ctr_reg, ctr_next;
    logic [sbfc_pkg::FREED_W-1:0] acc_reg, acc_next;
    logic [2:0]       st_reg, st_next;
    logic [HANDLE_BITS-1:0] gh_reg, gh_next;
    logic [RW-1:0]    gs_reg, gs_next;
    logic [PW-1:0]    prod_reg;
    logic             bytes_we;
    logic [BIW-1:0]   bytes_idx;
    logic [BYW-1:0]   bytes_wdata;
    logic             bytes_clr;

    always_ff @(posedge clk)
        prod_reg <= size_reg * excess_reg;

    // usable bins
    logic [6:0] span;
    logic [BW-1:0] nb_calc;
    always_comb
    begin
        span = {1'b0, last_reg} - {1'b0, first_reg} + 7'd1;
        if (last_reg < first_reg)
            nb_calc = '0;
        else if (span > 7'(BINS))
            nb_calc = BW'(BINS);
        else
            nb_calc = span[BW-1:0];
    end

    // bin of size_reg: first-one position
    logic [6:0] lg;
    logic [BW-1:0] bin_calc;
    logic [6:0] idx7;
    always_comb
    begin
        lg = '0;
        for (int i = 0; i < RW; i++)
            if (size_reg[i])
                lg = 7'(i);
        idx7 = lg - {1'b0, first_reg} + 7'd1;
        if (nb_reg == '0)
            bin_calc = '0;
        else if (last_reg < 6'(RW) && (size_reg >> last_reg) != '0)
            bin_calc = nb_reg;
        else if ((size_reg >> first_reg) == '0)
            bin_calc = '0;
        else if (idx7 >= 7'(nb_reg))
            bin_calc = nb_reg;
        else
            bin_calc = idx7[BW-1:0];
    end

    // bin floor of bin_reg compared to upper_reg
    logic [6:0] fl_exp;
    logic       floor_ok;
    always_comb
    begin
        fl_exp = {1'b0, first_reg} + 7'(bin_reg) - 7'd1;
        if (bin_reg == '0)
            floor_ok = 1'b1;
        else if (fl_exp > 7'(SW))
            floor_ok = 1'b0;
        else
            floor_ok = (upper_reg >> fl_exp) != '0;
    end

    logic [AW-1:0] base_addr;
    assign base_addr = AW'(bin_reg[BIW-1:0] * SLOTS_PER_BIN);
    assign cur_mask  = vmask_reg[bin_reg[BIW-1:0]];

    logic [SW-1:0] r_size;
    logic [HANDLE_BITS-1:0] r_hnd;
    logic [31:0] r_stamp, r_age;
    assign r_size  = rd_data[WW-1 -: SW];
    assign r_hnd   = rd_data[sbfc_pkg::STAMP_W +: HANDLE_BITS];
    assign r_stamp = rd_data[31:0];
    assign r_age   = ctr_reg - r_stamp;

    always_comb
    begin
        state_next = state_reg;
        cmd_next = cmd_reg; size_next = size_reg; hnd_next = hnd_reg;
        upper_next = upper_reg; nb_next = nb_reg; bin_next = bin_reg;
        k_next = k_reg; rk_next = rk_reg; rdv_next = 1'b0;
        found_next = found_reg; best_k_next = best_k_reg;
        best_size_next = best_size_reg; best_hnd_next = best_hnd_reg;
        best_age_next = best_age_reg; ctr_next = ctr_reg; acc_next = acc_reg;
        st_next = st_reg; gh_next = gh_reg; gs_next = gs_reg;
        mask_wdata = cur_mask;
        mem_we = 1'b0; mem_waddr = base_addr; mem_wdata = '0;
        mem_raddr = base_addr + AW'(k_reg[KW-1:0]);
        bytes_we = 1'b0; bytes_idx = bin_reg[BIW-1:0]; bytes_wdata = '0;
        bytes_clr = 1'b0;
        busy = (state_reg != sbfc_pkg::S_IDLE);
        done = 1'b0;
        unique case (state_reg)
            sbfc_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd_next = command; size_next = request_size;
                    hnd_next = block_handle; nb_next = nb_calc;
                    st_next = sbfc_pkg::ST_MISS; gh_next = '0; gs_next = '0;
                    acc_next = '0; k_next = '0; found_next = 1'b0;
                    bin_next = '0;
                    state_next = sbfc_pkg::S_MUL;
                end
            end
            sbfc_pkg::S_MUL:
            begin
                // prod_reg valid next cycle; compute bin now
                bin_next = bin_calc;
                k_next = '0;
                unique case (cmd_reg)
                    sbfc_pkg::CMD_RETURN:
                    begin
                        st_next = sbfc_pkg::ST_PASS;
                        state_next = (bin_calc < nb_reg) ? sbfc_pkg::S_RET_SCAN
                                                         : sbfc_pkg::S_DONE;
                    end
                    sbfc_pkg::CMD_ALLOC:  state_next = sbfc_pkg::S_AL_BIN;
                    sbfc_pkg::CMD_CLEAR:
                    begin
                        // clear walks every bin from the bottom
                        bin_next = '0;
                        state_next = sbfc_pkg::S_CL_SUM;
                    end
                    default:              state_next = sbfc_pkg::S_DONE;
                endcase
            end
            sbfc_pkg::S_RET_SCAN:
            begin
                // find free slot one per cycle
                if (!cur_mask[k_reg[KW-1:0]])
                begin
                    rk_next = k_reg[KW-1:0];
                    state_next = sbfc_pkg::S_RET_DONE;
                end
                else if (k_reg == KCW'(SLOTS_PER_BIN - 1))
                    state_next = sbfc_pkg::S_DONE;
                else
                    k_next = k_reg + 1'b1;
            end
            sbfc_pkg::S_RET_DONE:
            begin
                mem_we = 1'b1;
                mem_waddr = base_addr + AW'(rk_reg);
                mem_wdata = {size_reg[SW-1:0], hnd_reg, ctr_reg};
                mask_wdata[rk_reg] = 1'b1;
                ctr_next = ctr_reg + 32'd1;
                bytes_we = 1'b1;
                bytes_wdata = bytes_mem[bin_reg[BIW-1:0]] + BYW'(size_reg);
                st_next = sbfc_pkg::ST_CACHED;
                state_next = sbfc_pkg::S_DONE;
            end
            sbfc_pkg::S_AL_BIN:
            begin
                if (prod_reg[PW-1:4] > PW'((PW-4)'({SW{1'b1}})))
                    upper_next = {1'b0, {SW{1'b1}}};
                else
                    upper_next = (SW+1)'(prod_reg[PW-1:4]);
                state_next = sbfc_pkg::S_AL_SCAN;
            end
            sbfc_pkg::S_AL_SCAN:
            begin
                // enter a bin: check bounds, then stream slots
                if (bin_reg < nb_reg && floor_ok)
                begin
                    found_next = 1'b0; k_next = '0;
                    state_next = sbfc_pkg::S_AL_WAIT;
                end
                else
                    state_next = sbfc_pkg::S_DONE;
            end
            sbfc_pkg::S_AL_WAIT:
            begin
                // issue read k, evaluate read k-1
                if (rdv_reg && cur_mask[rk_reg]
                    && {{(RW){1'b0}}, r_size} >= (SW+RW)'(size_reg))
                begin
                    if (!found_reg || r_size < best_size_reg
                        || (r_size == best_size_reg && r_age > best_age_reg))
                    begin
                        found_next = 1'b1; best_k_next = rk_reg;
                        best_size_next = r_size; best_hnd_next = r_hnd;
                        best_age_next = r_age;
                    end
                end
                if (k_reg < KCW'(SLOTS_PER_BIN))
                begin
                    rdv_next = 1'b1; rk_next = k_reg[KW-1:0];
                    k_next = k_reg + 1'b1;
                end
                else if (rdv_reg)
                    rdv_next = 1'b0;
                else
                    state_next = sbfc_pkg::S_AL_EVAL;
            end
            sbfc_pkg::S_AL_EVAL:
            begin
                if (found_reg && {1'b0, best_size_reg} <= upper_reg)
                    state_next = sbfc_pkg::S_AL_TAKE;
                else
                begin
                    bin_next = bin_reg + 1'b1;
                    state_next = sbfc_pkg::S_AL_SCAN;
                end
            end
            sbfc_pkg::S_AL_TAKE:
            begin
                mask_wdata[best_k_reg] = 1'b0;
                bytes_we = 1'b1;
                bytes_wdata = bytes_mem[bin_reg[BIW-1:0]] - BYW'(best_size_reg);
                st_next = sbfc_pkg::ST_HIT;
                gh_next = best_hnd_reg;
                gs_next = RW'(best_size_reg);
                state_next = sbfc_pkg::S_DONE;
            end
            sbfc_pkg::S_CL_SUM:
            begin
                // one bin per cycle
                acc_next = acc_reg
                    + sbfc_pkg::FREED_W'(bytes_mem[bin_reg[BIW-1:0]]);
                if (bin_reg == BW'(BINS - 1))
                    state_next = sbfc_pkg::S_CLRSWEEP;
                else
                    bin_next = bin_reg + 1'b1;
            end
            sbfc_pkg::S_CLRSWEEP:
            begin
                bytes_clr = 1'b1;
                st_next = sbfc_pkg::ST_CLEARED;
                state_next = sbfc_pkg::S_DONE;
            end
            sbfc_pkg::S_DONE:
            begin
                done = 1'b1;
                state_next = sbfc_pkg::S_IDLE;
            end
            default: state_next = sbfc_pkg::S_IDLE;
        endcase
    end

    assign status         = st_reg;
    assign granted_handle = gh_reg;
    assign granted_size   = gs_reg;
    assign freed_bytes    = (st_reg == sbfc_pkg::ST_CLEARED) ? acc_reg : '0;

    // byte tallies and valid masks share the bin index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BINS; i++)
            begin
                bytes_mem[i] <= '0;
                vmask_reg[i] <= '0;
            end
        end
        else if (bytes_clr)
        begin
            for (int i = 0; i < BINS; i++)
            begin
                bytes_mem[i] <= '0;
                vmask_reg[i] <= '0;
            end
        end
        else if (bytes_we)
        begin
            bytes_mem[bytes_idx] <= bytes_wdata;
            vmask_reg[bytes_idx] <= mask_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sbfc_pkg::S_IDLE;
            ctr_reg   <= '0;
            rdv_reg   <= 1'b0;
            st_reg    <= sbfc_pkg::ST_MISS;
        end
        else
        begin
            state_reg <= state_next;
            ctr_reg   <= ctr_next;
            rdv_reg   <= rdv_next;
            st_reg    <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next; size_reg <= size_next; hnd_reg <= hnd_next;
        upper_reg <= upper_next; nb_reg <= nb_next; bin_reg <= bin_next;
        k_reg <= k_next; rk_reg <= rk_next; found_reg <= found_next;
        best_k_reg <= best_k_next; best_size_reg <= best_size_next;
        best_hnd_reg <= best_hnd_next; best_age_reg <= best_age_next;
        acc_reg <= acc_next; gh_reg <= gh_next; gs_reg <= gs_next;
    end

endmodule
